// File: design/jse_pkg.sv
`default_nettype none

package jse_pkg;

    // depth of the job queue between classifier and expander
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_NONE   = 8'h00;

    // what the expander has to produce for one input byte
    typedef enum logic [2:0] {
        K_MARK  = 3'd0,   // bare end marker
        K_BYTE  = 3'd1,   // one byte copied
        K_ESC   = 3'd2,   // backslash plus letter
        K_UNI   = 3'd3,   // backslash, u, four hex digits
        K_QMARK = 3'd4    // question mark for a long sequence
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] data;   // byte, escape letter or code point
        logic        last;   // job closes the string
    } t_job;

    typedef struct packed {
        logic [7:0] ch;
        logic       vld;
        logic       run_end;
        logic       str_end;
    } t_word;

    function automatic logic [7:0] escape_letter(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h08:   r = 8'h62;
            8'h09:   r = 8'h74;
            8'h0a:   r = 8'h6e;
            8'h0c:   r = 8'h66;
            8'h0d:   r = 8'h72;
            8'h22:   r = 8'h22;
            8'h2f:   r = 8'h2f;
            8'h5c:   r = 8'h5c;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // continuation bytes announced by a lead byte, zero if invalid
    function automatic logic [2:0] lead_extra(input logic [7:0] b);
        logic [2:0] r;
        priority if (b < 8'hc0) r = 3'd0;
        else if (b < 8'he0)     r = 3'd1;
        else if (b < 8'hf0)     r = 3'd2;
        else if (b < 8'hf8)     r = 3'd3;
        else if (b < 8'hfc)     r = 3'd4;
        else if (b < 8'hfe)     r = 3'd5;
        else                    r = 3'd0;
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) r = 8'h30 + {4'd0, n};
        else           r = 8'h57 + {4'd0, n};
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/json_string_escaper.sv
// throughput: one input word per cycle while s_axis_tready is high, one output
//   word per cycle while m_axis_tready is high; an escape pair is 2 output words
//   and a u-escape 6, the job queue (4 deep) absorbs bursts and s_axis_tready
//   falls only when it is full
// reset: synchronous active low; clears sequence state, queue and output, raw mode on
`default_nettype none

module json_string_escaper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // configuration: pass_unicode_raw
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,

    // input bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // last_byte

    // escaped text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] run_end, rest zero
    output logic             m_axis_tuser,   // byte_valid
    output logic             m_axis_tlast    // string_end
);

    jse_pkg::t_job  job, head;
    jse_pkg::t_word word;
    logic           push, pop, head_valid, full, in_accept;

    // config is always taken; the user must change it only between strings, the block does not enforce this
    assign o_cfg_ready   = 1'b1;

    // front takes a word whenever the queue has room
    assign s_axis_tready = !full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // classifier: utf-8 sequence tracking, one job per byte that yields text or ends the string
    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_valid),
        .i_cfg_raw(i_cfg_data),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_job    (job),
        .o_push   (push)
    );

    // decouples the classifier from the expander
    jse_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (job),
        .i_pop       (pop),
        .o_head      (head),
        .o_head_valid(head_valid),
        .o_full      (full)
    );

    // expander: turns each job into 1, 2 or 6 words behind an output register
    jse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_head_valid(head_valid),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .o_word      (word),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, word.run_end, word.ch};
    assign m_axis_tuser = word.vld;
    assign m_axis_tlast = word.str_end;

    // end of string always closes the run of its byte
    a_str_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[8])
        else $error("string end without run end");

    // a bare marker only ever closes a string
    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[8]
            && m_axis_tdata[7:0] == 8'd0)
        else $error("bare marker not at string end");

    // nothing is pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("job queue overflow");

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// File: design/jse_front.sv
`default_nettype none

module jse_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_raw,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    output jse_pkg::t_job       o_job,
    output logic                o_push
);

    logic       r_raw, n_raw;
    logic [2:0] r_need, n_need;
    logic [2:0] r_len, n_len;
    logic [7:0] r_lead, n_lead;
    logic [7:0] r_second, n_second;
    logic       r_discard, n_discard;

    logic [7:0] esc;
    logic [2:0] extra;
    logic       has_job;

    always_comb begin
        n_raw     = i_cfg_we ? i_cfg_raw : r_raw;
        n_need    = r_need;
        n_len     = r_len;
        n_lead    = r_lead;
        n_second  = r_second;
        n_discard = r_discard;
        has_job   = 1'b0;
        o_job     = '{kind: jse_pkg::K_MARK, data: 16'd0, last: i_last};
        esc       = jse_pkg::escape_letter(i_byte);
        extra     = jse_pkg::lead_extra(i_byte);

        if (r_discard) begin
            // byte dropped
        end else if (r_need != 3'd0) begin
            if (r_len - r_need == 3'd1) begin
                n_second = i_byte;
            end
            n_need = r_need - 3'd1;
            if (n_need == 3'd0) begin
                has_job = 1'b1;
                n_len   = 3'd0;
                if (r_len == 3'd2) begin
                    o_job.kind = jse_pkg::K_UNI;
                    o_job.data = {5'd0, r_lead[4:0], i_byte[5:0]};
                end else if (r_len == 3'd3) begin
                    o_job.kind = jse_pkg::K_UNI;
                    o_job.data = {r_lead[3:0], r_second[5:0], i_byte[5:0]};
                end else begin
                    o_job.kind = jse_pkg::K_QMARK;
                end
            end
        end else if (esc != 8'd0) begin
            has_job    = 1'b1;
            o_job.kind = jse_pkg::K_ESC;
            o_job.data = {8'd0, esc};
        end else if (!i_byte[7] || r_raw) begin
            has_job    = 1'b1;
            o_job.kind = jse_pkg::K_BYTE;
            o_job.data = {8'd0, i_byte};
        end else if (extra == 3'd0) begin
            n_discard = 1'b1;
        end else begin
            n_lead = i_byte;
            n_len  = extra + 3'd1;
            n_need = extra;
        end

        if (i_last) begin
            n_need    = 3'd0;
            n_len     = 3'd0;
            n_discard = 1'b0;
        end

        o_push = i_accept && (has_job || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw     <= 1'b1;
            r_need    <= 3'd0;
            r_len     <= 3'd0;
            r_lead    <= 8'd0;
            r_second  <= 8'd0;
            r_discard <= 1'b0;
        end else begin
            r_raw <= n_raw;
            if (i_accept) begin
                r_need    <= n_need;
                r_len     <= n_len;
                r_lead    <= n_lead;
                r_second  <= n_second;
                r_discard <= n_discard;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/jse_queue.sv
`default_nettype none

module jse_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire jse_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output jse_pkg::t_job       o_head,
    output logic                o_head_valid,
    output logic                o_full
);

    jse_pkg::t_job               r_mem [jse_pkg::QDEPTH];
    logic [jse_pkg::QAW-1:0]     r_wptr, r_rptr;
    logic [jse_pkg::QAW:0]       r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == (jse_pkg::QAW+1)'(jse_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: design/jse_back.sv
`default_nettype none

module jse_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jse_pkg::t_job  i_head,
    input  wire logic           i_head_valid,
    output logic                o_pop,
    output logic                o_valid,
    output jse_pkg::t_word      o_word,
    input  wire logic           i_ready
);

    jse_pkg::t_job  r_job, n_job;
    logic           r_busy, n_busy;
    logic [2:0]     r_idx, n_idx;
    logic           r_ovalid, n_ovalid;
    jse_pkg::t_word r_oword, n_oword;

    logic           adv;
    logic [2:0]     last_idx;
    logic [3:0]     nib;
    jse_pkg::t_word word;

    always_comb begin
        unique case (r_idx)
            3'd2:    nib = r_job.data[15:12];
            3'd3:    nib = r_job.data[11:8];
            3'd4:    nib = r_job.data[7:4];
            default: nib = r_job.data[3:0];
        endcase

        word.vld = 1'b1;
        unique case (r_job.kind)
            jse_pkg::K_MARK: begin
                last_idx = 3'd0;
                word.ch  = jse_pkg::CH_NONE;
                word.vld = 1'b0;
            end
            jse_pkg::K_BYTE: begin
                last_idx = 3'd0;
                word.ch  = r_job.data[7:0];
            end
            jse_pkg::K_ESC: begin
                last_idx = 3'd1;
                word.ch  = (r_idx == 3'd0) ? jse_pkg::CH_BSLASH : r_job.data[7:0];
            end
            jse_pkg::K_UNI: begin
                last_idx = 3'd5;
                if (r_idx == 3'd0)      word.ch = jse_pkg::CH_BSLASH;
                else if (r_idx == 3'd1) word.ch = jse_pkg::CH_U;
                else                    word.ch = jse_pkg::hex_digit(nib);
            end
            default: begin
                last_idx = 3'd0;
                word.ch  = jse_pkg::CH_QMARK;
            end
        endcase
        word.run_end = (r_idx == last_idx);
        word.str_end = word.run_end && r_job.last;
    end

    always_comb begin
        adv      = !r_ovalid || i_ready;
        n_job    = r_job;
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_oword  = r_oword;
        o_pop    = 1'b0;

        if (r_busy) begin
            if (adv) begin
                n_ovalid = 1'b1;
                n_oword  = word;
                if (word.run_end) begin
                    o_pop  = i_head_valid;
                    n_busy = i_head_valid;
                    n_job  = i_head;
                    n_idx  = 3'd0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
        end else begin
            if (adv) n_ovalid = 1'b0;
            if (i_head_valid) begin
                o_pop  = 1'b1;
                n_busy = 1'b1;
                n_job  = i_head;
                n_idx  = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_oword <= n_oword;
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_oword;

endmodule

`default_nettype wire
